FILE: rtl/joint_trajectory_interpolator_unit_defines.svh
// Assertion helpers shared by the interpolator RTL.
`ifndef JOINT_TRAJECTORY_INTERPOLATOR_UNIT_DEFINES_SVH
`define JOINT_TRAJECTORY_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define JTI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define JTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/jti_pkg.sv
package jti_pkg;

  localparam int MAX_JOINTS = 8;
  localparam int JOINT_W    = $clog2(MAX_JOINTS);
  localparam int JCNT_W     = JOINT_W + 1;
  localparam int STEP_BITS  = 16;
  localparam int ANGLE_W    = 32;
  localparam int S_W        = 17;
  localparam int Q_ONE      = 65536;
  localparam int MAG_W      = ANGLE_W + 1;
  localparam int MUL_A_W    = MAG_W;
  localparam int MUL_B_W    = 20;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int DIV_W      = 52;
  localparam int DEN_W      = 32;
  localparam int DCNT_W     = $clog2(DIV_W);

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_PLAN   = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_REWIND = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    PROF_LINEAR   = 2'd0,
    PROF_MIN_JERK = 2'd1,
    PROF_TRAP     = 2'd2,
    PROF_TRAP_ALT = 2'd3
  } prof_e;

  typedef enum logic [1:0] {
    CFG_CONTROL_FREQ  = 2'd0,
    CFG_MAX_ANG_VEL   = 2'd1,
    CFG_MIN_STEPS     = 2'd2,
    CFG_ACTIVE_JOINTS = 2'd3
  } cfg_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         joint_number;
    logic signed [31:0] start_angle;
    logic signed [31:0] end_angle;
    logic [1:0]         profile_kind;
  } jti_in_t;

  typedef struct packed {
    logic [2:0]         out_joint;
    logic signed [31:0] angle;
    logic [15:0]        planned_steps;
    logic [15:0]        current_step;
    logic               done_res;
    logic               last;
  } jti_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PL_SCAN,
    ST_PL_MUL,
    ST_PL_DIVLD,
    ST_PL_DIV,
    ST_PL_SET,
    ST_PL_EMIT,
    ST_ZR_EMIT,
    ST_TK_LOAD,
    ST_TK_DIV,
    ST_TK_TSET,
    ST_SH_FIRST,
    ST_MJ_MUL1,
    ST_MJ_T2,
    ST_MJ_MUL2,
    ST_MJ_T3P,
    ST_MJ_MUL3,
    ST_MJ_S,
    ST_TR_MUL,
    ST_TR_S,
    ST_BL_MUL,
    ST_BL_EMIT
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_SCAN,
    OP_PMUL,
    OP_PDIV_LOAD,
    OP_DIV_STEP,
    OP_PLAN_SET,
    OP_EMIT_PLAN,
    OP_EMIT_ZERO,
    OP_TICK_LOAD,
    OP_T_SET,
    OP_S_FIRST,
    OP_MUL_TT,
    OP_T2,
    OP_MUL_T2T,
    OP_T3P,
    OP_MUL_T3P,
    OP_S_MJ,
    OP_S_TRAP,
    OP_BL_MUL,
    OP_EMIT_TICK
  } dp_op_e;

  typedef struct packed {
    logic   accept;
    dp_op_e op;
  } jti_cmd_t;

  typedef struct packed {
    logic j_last;
    logic div_last;
    logic has_plan;
    logic n_one;
    logic shape_simple;
    logic is_mj;
  } jti_sts_t;

endpackage

FILE: rtl/joint_trajectory_interpolator_unit.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid_i/in_stall_o jti_in_t: load, plan, tick or rewind
// out      output     out_valid_o/out_stall_i jti_out_t: one per plan or tick joint
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Load and rewind finish when accepted. A plan scans the joints, multiplies
// and runs the shared radix-2 divider; a tick runs the same divider (not for
// a one-step plan), then one multiplier pass per shape term and per joint.
// Without a plan a tick gives zero angles. One transaction is in work at a time.
// Async active-low reset loads register defaults and clears the angle stores.
// A stalled output holds its register; the engine waits for the slot to free.
`include "joint_trajectory_interpolator_unit_defines.svh"

module joint_trajectory_interpolator_unit import jti_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  jti_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output jti_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  jti_cmd_t cmd;
  jti_sts_t sts;

  assign cfg_ready_o = 1'b1;

  jti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_data_i.req_type),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  jti_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

  `JTI_ASSERT_IMPL(a_emit_into_free_slot, (cmd.op == OP_EMIT_PLAN || cmd.op == OP_EMIT_ZERO || cmd.op == OP_EMIT_TICK), (!out_valid_o || !out_stall_i), "result written over a stalled one")
  `JTI_ASSERT_IMPL(a_idle_no_work, !in_stall_o, (cmd.op == OP_NONE), "datapath busy while idle")
  `JTI_ASSERT_NEXT(a_div_runs_out, (cmd.op == OP_DIV_STEP && !sts.div_last), (cmd.op == OP_DIV_STEP), "divider stopped early")

endmodule

FILE: rtl/jti_ctrl.sv
module jti_ctrl import jti_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic [1:0] req_type_i,
  input  logic     out_stall_i,
  input  jti_sts_t sts_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  output jti_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        out_free;
  logic        emit;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_e'(req_type_i))
            REQ_PLAN:   state_d = ST_PL_SCAN;
            REQ_TICK:   state_d = sts_i.has_plan ? ST_TK_LOAD : ST_ZR_EMIT;
            REQ_LOAD,
            REQ_REWIND: state_d = ST_IDLE;
          endcase
        end
      end
      ST_PL_SCAN:  if (sts_i.j_last) state_d = ST_PL_MUL;
      ST_PL_MUL:   state_d = ST_PL_DIVLD;
      ST_PL_DIVLD: state_d = ST_PL_DIV;
      ST_PL_DIV:   if (sts_i.div_last) state_d = ST_PL_SET;
      ST_PL_SET:   state_d = ST_PL_EMIT;
      ST_PL_EMIT:  if (out_free) state_d = ST_IDLE;
      ST_ZR_EMIT:  if (out_free && sts_i.j_last) state_d = ST_IDLE;
      ST_TK_LOAD:  state_d = sts_i.n_one ? ST_SH_FIRST : ST_TK_DIV;
      ST_TK_DIV:   if (sts_i.div_last) state_d = ST_TK_TSET;
      ST_TK_TSET:  state_d = ST_SH_FIRST;
      ST_SH_FIRST: begin
        if (sts_i.shape_simple) state_d = ST_BL_MUL;
        else if (sts_i.is_mj)   state_d = ST_MJ_MUL1;
        else                    state_d = ST_TR_MUL;
      end
      ST_MJ_MUL1:  state_d = ST_MJ_T2;
      ST_MJ_T2:    state_d = ST_MJ_MUL2;
      ST_MJ_MUL2:  state_d = ST_MJ_T3P;
      ST_MJ_T3P:   state_d = ST_MJ_MUL3;
      ST_MJ_MUL3:  state_d = ST_MJ_S;
      ST_MJ_S:     state_d = ST_BL_MUL;
      ST_TR_MUL:   state_d = ST_TR_S;
      ST_TR_S:     state_d = ST_BL_MUL;
      ST_BL_MUL:   state_d = ST_BL_EMIT;
      ST_BL_EMIT: begin
        if (out_free) state_d = sts_i.j_last ? ST_IDLE : ST_BL_MUL;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.accept = accept;
    cmd_o.op     = OP_NONE;
    unique case (state_q)
      ST_IDLE:     cmd_o.op = OP_NONE;
      ST_PL_SCAN:  cmd_o.op = OP_SCAN;
      ST_PL_MUL:   cmd_o.op = OP_PMUL;
      ST_PL_DIVLD: cmd_o.op = OP_PDIV_LOAD;
      ST_PL_DIV:   cmd_o.op = OP_DIV_STEP;
      ST_PL_SET:   cmd_o.op = OP_PLAN_SET;
      ST_PL_EMIT:  cmd_o.op = out_free ? OP_EMIT_PLAN : OP_NONE;
      ST_ZR_EMIT:  cmd_o.op = out_free ? OP_EMIT_ZERO : OP_NONE;
      ST_TK_LOAD:  cmd_o.op = OP_TICK_LOAD;
      ST_TK_DIV:   cmd_o.op = OP_DIV_STEP;
      ST_TK_TSET:  cmd_o.op = OP_T_SET;
      ST_SH_FIRST: cmd_o.op = OP_S_FIRST;
      ST_MJ_MUL1:  cmd_o.op = OP_MUL_TT;
      ST_MJ_T2:    cmd_o.op = OP_T2;
      ST_MJ_MUL2:  cmd_o.op = OP_MUL_T2T;
      ST_MJ_T3P:   cmd_o.op = OP_T3P;
      ST_MJ_MUL3:  cmd_o.op = OP_MUL_T3P;
      ST_MJ_S:     cmd_o.op = OP_S_MJ;
      ST_TR_MUL:   cmd_o.op = OP_MUL_TT;
      ST_TR_S:     cmd_o.op = OP_S_TRAP;
      ST_BL_MUL:   cmd_o.op = OP_BL_MUL;
      ST_BL_EMIT:  cmd_o.op = out_free ? OP_EMIT_TICK : OP_NONE;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  assign emit = (cmd_o.op == OP_EMIT_PLAN) || (cmd_o.op == OP_EMIT_ZERO) ||
                (cmd_o.op == OP_EMIT_TICK);

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/jti_dp.sv
module jti_dp import jti_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  jti_cmd_t    cmd_i,
  input  jti_in_t     in_data_i,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output jti_sts_t    sts_o,
  output jti_out_t    out_data_o
);

  localparam int RND_W = PROD_W - 15;

  function automatic logic [RND_W-1:0] rnd16(input logic [PROD_W-1:0] v);
    logic [PROD_W:0] sum;
    sum = {1'b0, v} + (PROD_W + 1)'(32768);
    return sum[PROD_W:16];
  endfunction

  // configuration
  logic [16:0] freq_q;
  logic [31:0] vel_q;
  logic [15:0] min_steps_q;
  logic [3:0]  act_q;

  // plan state
  logic signed [ANGLE_W-1:0] start_q [MAX_JOINTS];
  logic signed [ANGLE_W-1:0] end_q   [MAX_JOINTS];
  prof_e                     chosen_q;
  logic [STEP_BITS-1:0]      total_q;
  logic [STEP_BITS-1:0]      idx_q;
  logic                      has_plan_q;
  logic [JOINT_W-1:0]        j_q;
  logic [DCNT_W-1:0]         dcnt_q;

  // working registers
  prof_e                 prof_q;
  logic [MAG_W-1:0]      disp_q;
  logic [PROD_W-1:0]     prod_q;
  logic [DIV_W-1:0]      num_q;
  logic [DEN_W-1:0]      rem_q;
  logic [DIV_W-1:0]      quo_q;
  logic [DEN_W-1:0]      den_q;
  logic [STEP_BITS-1:0]  i_q;
  logic [S_W-1:0]        t_q, t2_q, t3_q, s_q;
  logic [MUL_B_W-1:0]    p_q;
  jti_out_t              out_q;

  logic [JCNT_W-1:0]        nj;
  logic                     j_last;
  logic signed [MAG_W-1:0]  diff;
  logic                     neg;
  logic [MAG_W-1:0]         mag;
  logic [31:0]              vel_eff;
  logic [15:0]              lo;
  logic [STEP_BITS-1:0]     n_eff, nm1, i_c;
  logic                     n_one;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [PROD_W-1:0]        prod_d;
  logic [19:0]              t5;
  logic                     reg_low, reg_mid, use_u;
  logic [S_W-1:0]           u;
  logic [20:0]              mid_v;
  logic [S_W-1:0]           s_first;
  logic [DEN_W:0]           rem_sh;
  logic                     ge;
  logic [STEP_BITS-1:0]     steps;
  logic [21:0]              p_full;
  logic [RND_W-1:0]         r_mj;
  logic [PROD_W-1:0]        trap_sum;
  logic [S_W-1:0]           trap_v;
  logic [RND_W-1:0]         q_bl;
  logic [ANGLE_W+1:0]       a_ext, ang_r;

  always_comb begin
    if (act_q == 4'd0) begin
      nj = JCNT_W'(1);
    end else if (JCNT_W'(act_q) > JCNT_W'(MAX_JOINTS)) begin
      nj = JCNT_W'(MAX_JOINTS);
    end else begin
      nj = JCNT_W'(act_q);
    end
  end
  assign j_last = ({1'b0, j_q} == (nj - JCNT_W'(1)));

  assign diff = {end_q[j_q][ANGLE_W-1], end_q[j_q]} -
                {start_q[j_q][ANGLE_W-1], start_q[j_q]};
  assign neg  = diff[MAG_W-1];
  assign mag  = neg ? MAG_W'(-diff) : MAG_W'(diff);

  assign vel_eff = (vel_q == 32'd0) ? 32'd1 : vel_q;
  assign lo      = (min_steps_q == 16'd0) ? 16'd1 : min_steps_q;
  assign n_eff   = (total_q == '0) ? STEP_BITS'(1) : total_q;
  assign nm1     = n_eff - STEP_BITS'(1);
  assign i_c     = (idx_q < nm1) ? idx_q : nm1;
  assign n_one   = (nm1 == '0);

  // profile regions: first fifth, middle, last fifth
  assign t5      = {1'b0, t_q, 2'b00} + 20'(t_q);
  assign reg_low = (t5 < 20'(Q_ONE));
  assign reg_mid = !reg_low && (t5 < 20'(4 * Q_ONE));
  assign use_u   = (chosen_q != PROF_MIN_JERK) && !reg_low && !reg_mid;
  assign u       = S_W'(Q_ONE) - t_q;
  assign mid_v   = {1'b0, t_q, 3'b000} + {3'b000, t_q, 1'b0} - 21'd65532;

  always_comb begin
    if (t_q == '0) begin
      s_first = '0;
    end else if (t_q >= S_W'(Q_ONE)) begin
      s_first = S_W'(Q_ONE);
    end else if (chosen_q == PROF_LINEAR) begin
      s_first = t_q;
    end else begin
      s_first = mid_v[19:3];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_PMUL:    begin mul_a = disp_q;                 mul_b = MUL_B_W'(freq_q); end
      OP_MUL_TT:  begin
        mul_a = MUL_A_W'(use_u ? u : t_q);
        mul_b = MUL_B_W'(use_u ? u : t_q);
      end
      OP_MUL_T2T: begin mul_a = MUL_A_W'(t2_q);         mul_b = MUL_B_W'(t_q); end
      OP_MUL_T3P: begin mul_a = MUL_A_W'(t3_q);         mul_b = p_q; end
      OP_BL_MUL:  begin mul_a = mag;                    mul_b = MUL_B_W'(s_q); end
      default:    begin mul_a = '0;                     mul_b = '0; end
    endcase
  end
  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_q, num_q[DIV_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  assign steps = (|quo_q[DIV_W-1:STEP_BITS]) ? {STEP_BITS{1'b1}} :
                 ((quo_q[STEP_BITS-1:0] < STEP_BITS'(lo)) ? STEP_BITS'(lo)
                                                          : quo_q[STEP_BITS-1:0]);

  assign p_full = 22'(10 * Q_ONE) - 22'({t_q, 4'b0000}) + 22'(t_q) +
                  22'({t2_q, 2'b00}) + 22'({t2_q, 1'b0});

  assign r_mj     = rnd16(prod_q);
  assign trap_sum = (prod_q << 4) + (prod_q << 3) + prod_q + PROD_W'(1 << 18);
  assign trap_v   = trap_sum[S_W+18:19];

  assign q_bl  = rnd16(prod_q);
  assign a_ext = {{2{start_q[j_q][ANGLE_W-1]}}, start_q[j_q]};
  assign ang_r = neg ? a_ext - q_bl[ANGLE_W+1:0] : a_ext + q_bl[ANGLE_W+1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q      <= 17'd1000;
      vel_q       <= 32'd65536;
      min_steps_q <= 16'd10;
      act_q       <= 4'd7;
      for (int k = 0; k < MAX_JOINTS; k++) begin
        start_q[k] <= '0;
        end_q[k]   <= '0;
      end
      chosen_q    <= PROF_TRAP;
      total_q     <= STEP_BITS'(10);
      idx_q       <= '0;
      has_plan_q  <= 1'b0;
      j_q         <= '0;
      dcnt_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_CONTROL_FREQ:  freq_q      <= cfg_data_i[16:0];
          CFG_MAX_ANG_VEL:   vel_q       <= cfg_data_i;
          CFG_MIN_STEPS:     min_steps_q <= cfg_data_i[15:0];
          CFG_ACTIVE_JOINTS: act_q       <= cfg_data_i[3:0];
        endcase
      end
      if (cmd_i.accept) begin
        j_q <= '0;
        unique case (req_e'(in_data_i.req_type))
          REQ_LOAD: begin
            start_q[in_data_i.joint_number] <= in_data_i.start_angle;
            end_q[in_data_i.joint_number]   <= in_data_i.end_angle;
          end
          REQ_REWIND: idx_q <= '0;
          REQ_PLAN, REQ_TICK: ;
        endcase
      end
      case (cmd_i.op)
        OP_SCAN, OP_EMIT_ZERO: j_q <= j_q + JOINT_W'(1);
        OP_PDIV_LOAD, OP_TICK_LOAD: dcnt_q <= '0;
        OP_DIV_STEP: dcnt_q <= dcnt_q + DCNT_W'(1);
        OP_PLAN_SET: begin
          total_q    <= steps;
          idx_q      <= '0;
          chosen_q   <= prof_q;
          has_plan_q <= 1'b1;
        end
        OP_EMIT_TICK: begin
          j_q <= j_q + JOINT_W'(1);
          if (j_last && (i_q < nm1)) begin
            idx_q <= i_q + STEP_BITS'(1);
          end else if (j_last) begin
            idx_q <= i_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      prof_q <= prof_e'(in_data_i.profile_kind);
      disp_q <= '0;
    end
    case (cmd_i.op)
      OP_SCAN: if (mag > disp_q) disp_q <= mag;
      OP_PMUL, OP_MUL_TT, OP_MUL_T2T, OP_MUL_T3P, OP_BL_MUL: prod_q <= prod_d;
      OP_PDIV_LOAD: begin
        num_q <= prod_q[DIV_W-1:0] + DIV_W'(vel_eff - 32'd1);
        den_q <= vel_eff;
        rem_q <= '0;
        quo_q <= '0;
      end
      OP_TICK_LOAD: begin
        i_q   <= i_c;
        num_q <= DIV_W'({i_c, 17'd0}) + DIV_W'(nm1);
        den_q <= DEN_W'({nm1, 1'b0});
        rem_q <= '0;
        quo_q <= '0;
        if (n_one) t_q <= S_W'(Q_ONE);
      end
      OP_DIV_STEP: begin
        rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
        num_q <= {num_q[DIV_W-2:0], 1'b0};
        quo_q <= {quo_q[DIV_W-2:0], ge};
      end
      OP_T_SET:   t_q <= quo_q[S_W-1:0];
      OP_S_FIRST: s_q <= s_first;
      OP_T2:      t2_q <= r_mj[S_W-1:0];
      OP_T3P: begin
        t3_q <= r_mj[S_W-1:0];
        p_q  <= p_full[MUL_B_W-1:0];
      end
      OP_S_MJ: s_q <= (r_mj > RND_W'(Q_ONE)) ? S_W'(Q_ONE) : r_mj[S_W-1:0];
      OP_S_TRAP: s_q <= use_u ? S_W'(Q_ONE) - trap_v : trap_v;
      OP_EMIT_PLAN: begin
        out_q.out_joint     <= '0;
        out_q.angle         <= '0;
        out_q.planned_steps <= total_q[15:0];
        out_q.current_step  <= '0;
        out_q.done_res      <= (total_q <= STEP_BITS'(1));
        out_q.last          <= 1'b1;
      end
      OP_EMIT_ZERO: begin
        out_q.out_joint     <= 3'(j_q);
        out_q.angle         <= '0;
        out_q.planned_steps <= total_q[15:0];
        out_q.current_step  <= '0;
        out_q.done_res      <= 1'b0;
        out_q.last          <= j_last;
      end
      OP_EMIT_TICK: begin
        out_q.out_joint     <= 3'(j_q);
        out_q.angle         <= ang_r[ANGLE_W-1:0];
        out_q.planned_steps <= total_q[15:0];
        out_q.current_step  <= i_q[15:0];
        out_q.done_res      <= (i_q == nm1);
        out_q.last          <= j_last;
      end
      default: ;
    endcase
  end

  assign sts_o.j_last       = j_last;
  assign sts_o.div_last     = (dcnt_q == DCNT_W'(DIV_W - 1));
  assign sts_o.has_plan     = has_plan_q;
  assign sts_o.n_one        = n_one;
  assign sts_o.shape_simple = (t_q == '0) || (t_q >= S_W'(Q_ONE)) ||
                              (chosen_q == PROF_LINEAR) ||
                              ((chosen_q != PROF_MIN_JERK) && reg_mid);
  assign sts_o.is_mj        = (chosen_q == PROF_MIN_JERK);

  assign out_data_o = out_q;

endmodule

FILE: bench/tb.sv
module tb;
  import jti_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  jti_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  jti_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  joint_trajectory_interpolator_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow of the block: registers and trajectory state
  logic [16:0]        ctl_freq;
  logic [31:0]        ang_vel;
  logic [15:0]        min_cnt;
  logic [3:0]         act_joints;
  logic signed [31:0] pos_from [MAX_JOINTS];
  logic signed [31:0] pos_to [MAX_JOINTS];
  logic [1:0]         prof_sel;
  longint unsigned    step_cnt;
  longint unsigned    step_at;
  bit                 planned;

  jti_out_t waypoint_q[$];
  int       errors = 0;
  int       cycles = 0;
  bit       quiet = 1'b0;

  typedef struct {
    jti_in_t  item;
    bit       typed;
    jti_out_t first;
  } row_t;
  row_t dir_tab[$];

  task automatic report(string msg);
    $display("MISMATCH @%0t: %0s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want) report($sformatf("%0s got %0h want %0h", name, got, want));
  endtask

  function automatic longint unsigned rnd_q16(longint unsigned v);
    return (v + 64'd32768) >> 16;
  endfunction

  function automatic longint unsigned lim_s(longint s);
    if (s < 0) return 0;
    if (s > Q_ONE) return Q_ONE;
    return s;
  endfunction

  function automatic longint unsigned profile_val(longint unsigned t, logic [1:0] kind);
    longint unsigned t2, t3, u;
    longint p;
    if (t == 0) return 0;
    if (t >= Q_ONE) return Q_ONE;
    if (kind == PROF_LINEAR) return t;
    if (kind == PROF_MIN_JERK) begin
      t2 = rnd_q16(t * t);
      t3 = rnd_q16(t2 * t);
      p = 10 * longint'(Q_ONE) - 15 * longint'(t) + 6 * longint'(t2);
      return lim_s(longint'(rnd_q16(t3 * longint'(p))));
    end
    if (5 * t < Q_ONE) return lim_s(longint'((25 * t * t + (64'd1 << 18)) >> 19));
    if (5 * t < 4 * Q_ONE) return lim_s((10 * longint'(t) - Q_ONE + 4) / 8);
    u = Q_ONE - t;
    return lim_s(longint'(Q_ONE) - longint'((25 * u * u + (64'd1 << 18)) >> 19));
  endfunction

  function automatic logic [31:0] mix_angle(logic signed [31:0] a, logic signed [31:0] b,
                                            longint unsigned s);
    longint d, r;
    longint unsigned mag, q;
    d = longint'(b) - longint'(a);
    mag = (d < 0) ? longint'(-d) : d;
    q = rnd_q16(mag * s);
    r = (d < 0) ? longint'(a) - longint'(q) : longint'(a) + longint'(q);
    return r[31:0];
  endfunction

  function automatic int unsigned joints_in_use();
    if (act_joints == 0) return 1;
    if (act_joints > MAX_JOINTS) return MAX_JOINTS;
    return act_joints;
  endfunction

  task automatic push_wp(int unsigned j, logic [31:0] ang, longint unsigned cur,
                         bit done, bit lst);
    jti_out_t r;
    r.out_joint = j[2:0];
    r.angle = ang;
    r.planned_steps = step_cnt[15:0];
    r.current_step = cur[15:0];
    r.done_res = done;
    r.last = lst;
    waypoint_q.push_back(r);
  endtask

  task automatic predict_waypoints(jti_in_t it);
    int unsigned nj;
    longint unsigned disp, m, vel, lo, st, n, i, t, s;
    longint d;
    bit done;
    nj = joints_in_use();
    case (it.req_type)
      REQ_LOAD: begin
        pos_from[it.joint_number] = it.start_angle;
        pos_to[it.joint_number] = it.end_angle;
      end
      REQ_PLAN: begin
        disp = 0;
        for (int j = 0; j < nj; j++) begin
          d = longint'(pos_to[j]) - longint'(pos_from[j]);
          m = (d < 0) ? longint'(-d) : d;
          if (m > disp) disp = m;
        end
        vel = (ang_vel != 0) ? ang_vel : 1;
        st = (disp * ctl_freq + vel - 1) / vel;
        lo = (min_cnt != 0) ? min_cnt : 1;
        if (st < lo) st = lo;
        if (st > 65535) st = 65535;
        step_cnt = st;
        step_at = 0;
        prof_sel = it.profile_kind;
        planned = 1'b1;
        push_wp(0, '0, 0, step_cnt <= 1, 1'b1);
      end
      REQ_REWIND: step_at = 0;
      default: begin
        if (!planned) begin
          for (int j = 0; j < nj; j++) push_wp(j, '0, 0, 1'b0, j + 1 == nj);
        end else begin
          n = (step_cnt != 0) ? step_cnt : 1;
          i = (step_at < n - 1) ? step_at : n - 1;
          if (n > 1) t = (i * Q_ONE * 2 + (n - 1)) / (2 * (n - 1));
          else t = Q_ONE;
          s = profile_val(t, prof_sel);
          done = (i >= n - 1);
          for (int j = 0; j < nj; j++)
            push_wp(j, mix_angle(pos_from[j], pos_to[j], s), i, done, j + 1 == nj);
          if (i < n - 1) i++;
          step_at = i & 64'hFFFF;
        end
      end
    endcase
  endtask

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // caller stands at a rising edge
  task automatic send_item(jti_in_t it, bit typed = 1'b0, jti_out_t first = '0);
    int g, base;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    base = waypoint_q.size();
    predict_waypoints(it);
    if (typed) waypoint_q[base] = first;
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    while (waypoint_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_CONTROL_FREQ: ctl_freq = val[16:0];
      CFG_MAX_ANG_VEL:  ang_vel = val;
      CFG_MIN_STEPS:    min_cnt = val[15:0];
      default:          act_joints = val[3:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] f, logic [31:0] v, logic [31:0] ms, logic [31:0] aj);
    cfg_write(CFG_CONTROL_FREQ, f);
    cfg_write(CFG_MAX_ANG_VEL, v);
    cfg_write(CFG_MIN_STEPS, ms);
    cfg_write(CFG_ACTIVE_JOINTS, aj);
  endtask

  function automatic jti_in_t mk(req_e rq, int jn, logic [31:0] sa, logic [31:0] ea,
                                 prof_e pf);
    jti_in_t it;
    it.req_type = rq;
    it.joint_number = jn[2:0];
    it.start_angle = sa;
    it.end_angle = ea;
    it.profile_kind = pf;
    return it;
  endfunction

  function automatic jti_out_t mk_wp(int j, logic [31:0] ang, int ps, bit done, bit lst);
    jti_out_t r;
    r.out_joint = j[2:0];
    r.angle = ang;
    r.planned_steps = ps[15:0];
    r.current_step = '0;
    r.done_res = done;
    r.last = lst;
    return r;
  endfunction

  task automatic add_row(jti_in_t it, bit typed = 1'b0, jti_out_t first = '0);
    row_t r;
    r.item = it;
    r.typed = typed;
    r.first = first;
    dir_tab.push_back(r);
  endtask

  // mostly small displacements so plans stay short enough to finish
  task automatic rand_load();
    logic [31:0] a, b;
    a = $urandom;
    if ($urandom_range(0, 3) == 0) b = $urandom;
    else b = a + ($urandom_range(0, 1) ? 1 : -1) * ($urandom & ((32'd1 << $urandom_range(0, 16)) - 1));
    send_item(mk(REQ_LOAD, $urandom_range(0, 7), a, b, prof_e'($urandom_range(0, 3))));
  endtask

  task automatic rand_phase(int items, bit hold_once);
    int cnt;
    jti_in_t it;
    cnt = 0;
    while (cnt < items) begin
      if (hold_once && cnt >= items / 2) begin
        hold_once = 1'b0;
        in_valid_i <= 1'b0;
        while (waypoint_q.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 99) < 80) begin
        repeat ($urandom_range(0, joints_in_use() + 1)) begin
          rand_load();
          cnt++;
        end
        send_item(mk(REQ_PLAN, $urandom_range(0, 7), $urandom, $urandom,
                     prof_e'($urandom_range(0, 3))));
        cnt++;
        repeat ($urandom_range(1, 14)) begin
          if ($urandom_range(0, 19) == 0) it = mk(REQ_REWIND, 0, $urandom, $urandom, PROF_LINEAR);
          else it = mk(REQ_TICK, $urandom_range(0, 7), $urandom, $urandom,
                       prof_e'($urandom_range(0, 3)));
          send_item(it);
          cnt++;
        end
      end else begin
        it = mk(req_e'($urandom_range(0, 3)), $urandom_range(0, 7), $urandom, $urandom,
                prof_e'($urandom_range(0, 3)));
        send_item(it);
        cnt++;
      end
    end
  endtask

  // output side: random stall runs and the checker
  int stall_run = 0;
  always @(posedge clk_i) begin
    int r;
    jti_out_t w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (waypoint_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          w = waypoint_q.pop_front();
          check_field("out_joint", out_data_o.out_joint, w.out_joint);
          check_field("angle", out_data_o.angle, w.angle);
          check_field("planned_steps", out_data_o.planned_steps, w.planned_steps);
          check_field("current_step", out_data_o.current_step, w.current_step);
          check_field("done_res", out_data_o.done_res, w.done_res);
          check_field("last", out_data_o.last, w.last);
        end
      end
      if (stall_run > 0) begin
        stall_run--;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall_i <= 1'b0;
          stall_run = $urandom_range(0, 8);
        end else if (r < 92) begin
          out_stall_i <= 1'b1;
          stall_run = $urandom_range(0, 2);
        end else begin
          out_stall_i <= 1'b1;
          stall_run = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin
    ctl_freq = 17'd1000;
    ang_vel = 32'd65536;
    min_cnt = 16'd10;
    act_joints = 4'd7;
    for (int j = 0; j < MAX_JOINTS; j++) begin
      pos_from[j] = '0;
      pos_to[j] = '0;
    end
    prof_sel = PROF_TRAP;
    step_cnt = 10;
    step_at = 0;
    planned = 1'b0;

    add_row(mk(REQ_TICK, 0, 0, 0, PROF_LINEAR), 1'b1, mk_wp(0, 0, 10, 0, 0));
    add_row(mk(REQ_LOAD, 0, 32'h8000_0000, 32'h7FFF_FFFF, PROF_LINEAR));
    add_row(mk(REQ_LOAD, 1, 32'h7FFF_FFFF, 32'h8000_0000, PROF_LINEAR));
    add_row(mk(REQ_LOAD, 2, 32'h0001_0000, 32'hFFFE_0000, PROF_LINEAR));
    add_row(mk(REQ_LOAD, 7, 32'hFFFF_FFFF, 32'h0001_2345, PROF_LINEAR));
    add_row(mk(REQ_PLAN, 0, 0, 0, PROF_LINEAR), 1'b1, mk_wp(0, 0, 65535, 0, 1));
    add_row(mk(REQ_TICK, 0, 0, 0, PROF_LINEAR), 1'b1,
            mk_wp(0, 32'h8000_0000, 65535, 0, 0));
    add_row(mk(REQ_TICK, 0, 0, 0, PROF_LINEAR));
    add_row(mk(REQ_REWIND, 0, 0, 0, PROF_LINEAR));
    add_row(mk(REQ_TICK, 0, 0, 0, PROF_LINEAR));
    add_row(mk(REQ_LOAD, 0, 0, 32'h200, PROF_LINEAR));
    add_row(mk(REQ_LOAD, 1, 32'h100, 0, PROF_LINEAR));
    add_row(mk(REQ_LOAD, 2, -5, 5, PROF_LINEAR));
    add_row(mk(REQ_PLAN, 0, 0, 0, PROF_MIN_JERK));
    add_row(mk(REQ_TICK, 0, 0, 0, PROF_LINEAR));
    add_row(mk(REQ_TICK, 0, 0, 0, PROF_LINEAR));
    add_row(mk(REQ_TICK, 0, 0, 0, PROF_LINEAR));
    add_row(mk(REQ_PLAN, 0, 0, 0, PROF_TRAP));
    add_row(mk(REQ_TICK, 0, 0, 0, PROF_LINEAR));
    add_row(mk(REQ_TICK, 0, 0, 0, PROF_LINEAR));
    add_row(mk(REQ_PLAN, 0, 0, 0, PROF_TRAP_ALT));
    add_row(mk(REQ_TICK, 0, 0, 0, PROF_LINEAR));
    add_row(mk(REQ_REWIND, 0, 0, 0, PROF_LINEAR));
    add_row(mk(REQ_TICK, 0, 0, 0, PROF_LINEAR));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_tab[k]) send_item(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].first);
    drain_wait();

    set_regs(1000, 32'h0010_0000, 3, 3);
    rand_phase(80, 1'b1);
    drain_wait();

    quiet = 1'b1;
    set_regs(100000, 32'hFFFF_FFFF, 1, 8);
    rand_phase(80, 1'b0);
    drain_wait();
    quiet = 1'b0;

    // zero velocity, minimum-step and joint registers fall back to their floors
    set_regs(0, 0, 0, 0);
    rand_phase(80, 1'b0);
    drain_wait();

    set_regs(1, 1, 65535, 12);
    rand_phase(80, 1'b0);
    drain_wait();

    set_regs($urandom_range(1, 100000), $urandom | 32'h1, $urandom_range(1, 20),
             $urandom_range(1, 8));
    rand_phase(80, 1'b0);

    in_valid_i <= 1'b0;
    while (waypoint_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/jti_pkg.sv
rtl/jti_ctrl.sv
rtl/jti_dp.sv
rtl/joint_trajectory_interpolator_unit.sv
bench/tb.sv
